>>> hdl/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg: shared types and constants of the segment offset map
// Request and result layouts, operation and status codes, the micro-op set
// and the control store of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package som_pkg;

	// fixed field widths of the stream payload
	localparam int SEQ_LEN_W = 32;
	localparam int IN_POS_W  = 40;
	localparam int SEQ_ID_W  = 8;
	localparam int SEQ_OFF_W = 32;
	localparam int IDX_OUT_W = 9;
	localparam int OUT_POS_W = 40;
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 136;
	localparam int M_PAD_W   = M_TDATA_W - IDX_OUT_W - 3 * OUT_POS_W;

	// operation selector
	typedef enum logic [1:0] {
		FN_CLEAR     = 2'd0,
		FN_APPEND    = 2'd1,
		FN_LOCATE    = 2'd2,
		FN_GLOBALIZE = 2'd3
	} func_t;

	// result status
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// captured request fields
	typedef struct packed {
		logic [SEQ_LEN_W-1:0] seq_length;
		logic [IN_POS_W-1:0]  genome_pos;
		logic [SEQ_ID_W-1:0]  seq_id;
		logic [SEQ_OFF_W-1:0] seq_offset;
	} req_t;

	// one result
	typedef struct packed {
		status_t              status;
		logic [IDX_OUT_W-1:0] found_index;
		logic [OUT_POS_W-1:0] found_offset;
		logic [OUT_POS_W-1:0] global_result;
		logic [OUT_POS_W-1:0] length_sum;
	} res_t;

	// datapath micro-operations
	typedef enum logic [2:0] {
		U_NOP,
		U_CLEAR,
		U_APPEND,
		U_SRCH_INIT,
		U_SRCH_STEP,
		U_LOC_FIN,
		U_GLB_RD,
		U_GLB_FIN
	} uop_t;

	// sequencing conditions
	typedef enum logic [1:0] {
		C_DISPATCH,
		C_NEXT,
		C_SRCH,
		C_EMIT
	} cond_t;

	// program steps
	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_APPEND,
		S_LOC_INIT,
		S_LOC_SRCH,
		S_LOC_FIN,
		S_GLB_RD,
		S_GLB_FIN
	} step_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		uop_t uop;
		logic exec;
		logic emit;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic srch_done;
	} dp_flags_t;

	// control store
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		unique case (step)
			S_IDLE:     w = '{uop: U_NOP,       cond: C_DISPATCH, target: S_IDLE};
			S_CLEAR:    w = '{uop: U_CLEAR,     cond: C_EMIT,     target: S_IDLE};
			S_APPEND:   w = '{uop: U_APPEND,    cond: C_EMIT,     target: S_IDLE};
			S_LOC_INIT: w = '{uop: U_SRCH_INIT, cond: C_NEXT,     target: S_LOC_SRCH};
			S_LOC_SRCH: w = '{uop: U_SRCH_STEP, cond: C_SRCH,     target: S_LOC_FIN};
			S_LOC_FIN:  w = '{uop: U_LOC_FIN,   cond: C_EMIT,     target: S_IDLE};
			S_GLB_RD:   w = '{uop: U_GLB_RD,    cond: C_NEXT,     target: S_GLB_FIN};
			S_GLB_FIN:  w = '{uop: U_GLB_FIN,   cond: C_EMIT,     target: S_IDLE};
			default:    w = '{uop: U_NOP,       cond: C_DISPATCH, target: S_IDLE};
		endcase
		return w;
	endfunction

	// entry step of each operation
	function automatic step_t dispatch_step(func_t func);
		step_t s;
		unique case (func)
			FN_CLEAR:     s = S_CLEAR;
			FN_APPEND:    s = S_APPEND;
			FN_LOCATE:    s = S_LOC_INIT;
			FN_GLOBALIZE: s = S_GLB_RD;
			default:      s = S_IDLE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> hdl/som_useq.sv
// ----------------------------------------------------------------------------
// som_useq: microcode sequencer
// Step register, control store lookup and conditional jumps; issues one
// micro-op per cycle to the datapath unless the output register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module som_useq
	import som_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  func_t      func,
	input  wire        out_free,
	input  dp_flags_t  flags,
	output logic       in_ready,
	output ctrl_t      ctrl
);

	step_t  step_q;
	step_t  step_d;
	ucode_t uw;

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// control word decode and jump logic
	always_comb begin
		uw        = ucode_rom(step_q);
		step_d    = step_q;
		in_ready  = 1'b0;
		ctrl.uop  = uw.uop;
		ctrl.exec = 1'b0;
		ctrl.emit = 1'b0;
		unique case (uw.cond)
			C_DISPATCH: begin
				in_ready = 1'b1;
				if (in_valid) begin
					step_d = dispatch_step(func);
				end
			end
			C_NEXT: begin
				ctrl.exec = 1'b1;
				step_d    = step_t'(step_q + 3'd1);
			end
			C_SRCH: begin
				ctrl.exec = 1'b1;
				if (flags.srch_done) begin
					step_d = uw.target;
				end
			end
			C_EMIT: begin
				ctrl.exec = out_free;
				ctrl.emit = out_free;
				if (out_free) begin
					step_d = uw.target;
				end
			end
			default: begin
				step_d = S_IDLE;
			end
		endcase
	end

	// a result is only written into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> out_free)
		else $error("result issued while output register occupied");

	// an accepted request always starts a program
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (step_q != S_IDLE))
		else $error("accepted request did not start a program");

	// the search step only exits once the interval has closed
	a_srch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_LOC_SRCH && !flags.srch_done) |=> (step_q == S_LOC_SRCH))
		else $error("search left before completion");

endmodule

`default_nettype wire

>>> hdl/som_datapath.sv
// ----------------------------------------------------------------------------
// som_datapath: table state, end-sum and length memories, search registers
// Executes one micro-op per cycle while exec is set and forms each result.
// ----------------------------------------------------------------------------
`default_nettype none

module som_datapath
	import som_pkg::*;
#(
	parameter int MAX_SEQS  = 256,
	parameter int POS_WIDTH = 40
) (
	input  wire        clk,
	input  wire        arst_n,
	input  ctrl_t      ctrl,
	input  req_t       req,
	output dp_flags_t  flags,
	output res_t       res
);

	localparam int CNT_W = $clog2(MAX_SEQS + 1);
	localparam int AW    = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
	localparam int ID_W  = (CNT_W > SEQ_ID_W) ? CNT_W : SEQ_ID_W;

	// table state
	logic [CNT_W-1:0]     count_q, count_d;
	logic [POS_WIDTH-1:0] total_q, total_d;

	// search state
	logic [CNT_W-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [POS_WIDTH-1:0] start_q, start_d;

	// memories and their read registers
	logic [POS_WIDTH-1:0] end_sums_q [MAX_SEQS];
	logic [SEQ_LEN_W-1:0] lengths_q  [MAX_SEQS];
	logic [POS_WIDTH-1:0] end_rd_q;
	logic [SEQ_LEN_W-1:0] len_rd_q;

	logic                 wr_en, rd_en;
	logic [AW-1:0]        end_addr, len_addr;

	// working values
	logic [POS_WIDTH-1:0] pos, add_total, foff, glob_start, glob;
	logic                 full, gt, id_ok, off_ok;
	logic [CNT_W-1:0]     lo_s, hi_s, mid_s, mid_init;
	logic [CNT_W:0]       mid_sum;
	logic [POS_WIDTH-1:0] start_s;

	assign pos             = POS_WIDTH'(req.genome_pos);
	assign add_total       = total_q + POS_WIDTH'(req.seq_length);
	assign full            = (count_q == CNT_W'(MAX_SEQS));
	assign flags.srch_done = (lo_q == hi_q);
	assign mid_init        = count_q >> 1;

	// one probe of the binary search: first entry whose end exceeds pos
	always_comb begin
		gt      = (end_rd_q > pos);
		lo_s    = lo_q;
		hi_s    = hi_q;
		start_s = start_q;
		if (gt) begin
			hi_s = mid_q;
		end else begin
			lo_s    = mid_q + CNT_W'(1);
			start_s = end_rd_q;
		end
		mid_sum = {1'b0, lo_s} + {1'b0, hi_s};
		mid_s   = mid_sum[CNT_W:1];
	end

	// globalize checks on the read-back entry, and the locate offset
	always_comb begin
		id_ok      = (ID_W'(req.seq_id) < ID_W'(count_q));
		off_ok     = (req.seq_offset < len_rd_q);
		glob_start = (req.seq_id == '0) ? '0 : end_rd_q;
		glob       = glob_start + POS_WIDTH'(req.seq_offset);
		foff       = (lo_q == count_q) ? (pos - total_q) : (pos - start_q);
	end

	// micro-op decode
	always_comb begin
		count_d           = count_q;
		total_d           = total_q;
		lo_d              = lo_q;
		hi_d              = hi_q;
		mid_d             = mid_q;
		start_d           = start_q;
		wr_en             = 1'b0;
		rd_en             = 1'b0;
		end_addr          = mid_q[AW-1:0];
		len_addr          = AW'(req.seq_id);
		res.status        = STS_OK;
		res.found_index   = '0;
		res.found_offset  = '0;
		res.global_result = '0;
		res.length_sum    = OUT_POS_W'(total_q);
		if (ctrl.exec) begin
			unique case (ctrl.uop)
				U_NOP: begin
				end
				U_CLEAR: begin
					count_d        = '0;
					total_d        = '0;
					res.length_sum = '0;
				end
				U_APPEND: begin
					if (full) begin
						res.status = STS_FULL;
					end else begin
						wr_en          = 1'b1;
						total_d        = add_total;
						count_d        = count_q + CNT_W'(1);
						res.length_sum = OUT_POS_W'(add_total);
					end
				end
				U_SRCH_INIT: begin
					lo_d     = '0;
					hi_d     = count_q;
					start_d  = '0;
					mid_d    = mid_init;
					rd_en    = 1'b1;
					end_addr = mid_init[AW-1:0];
				end
				U_SRCH_STEP: begin
					if (!flags.srch_done) begin
						lo_d     = lo_s;
						hi_d     = hi_s;
						start_d  = start_s;
						mid_d    = mid_s;
						rd_en    = 1'b1;
						end_addr = mid_s[AW-1:0];
					end
				end
				U_LOC_FIN: begin
					res.status       = (pos < total_q) ? STS_OK : STS_RANGE;
					res.found_index  = IDX_OUT_W'(lo_q);
					res.found_offset = OUT_POS_W'(foff);
				end
				U_GLB_RD: begin
					rd_en    = 1'b1;
					end_addr = AW'(req.seq_id - SEQ_ID_W'(1));
					len_addr = AW'(req.seq_id);
				end
				U_GLB_FIN: begin
					if (id_ok && off_ok) begin
						res.global_result = OUT_POS_W'(glob);
					end else begin
						res.status = STS_RANGE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
		end else begin
			count_q <= count_d;
			total_q <= total_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			mid_q   <= mid_d;
		end
	end

	// start of the current lower bound
	always_ff @(posedge clk) begin
		start_q <= start_d;
	end

	// memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr_en) begin
			end_sums_q[count_q[AW-1:0]] <= add_total;
			lengths_q[count_q[AW-1:0]]  <= req.seq_length;
		end
		if (rd_en) begin
			end_rd_q <= end_sums_q[end_addr];
			len_rd_q <= lengths_q[len_addr];
		end
	end

	// fill count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEQS))
		else $error("entry count beyond table depth");

	// the search interval never inverts
	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && ctrl.uop == U_SRCH_STEP) |-> (lo_q <= hi_q))
		else $error("search interval inverted");

endmodule

`default_nettype wire

>>> hdl/segment_offset_map_top.sv
// ----------------------------------------------------------------------------
// segment_offset_map_top: concatenated coordinate map over a length table
// Stream wrapper with request capture and output register around the
// microcoded sequencer and its datapath.
// ----------------------------------------------------------------------------
// One request is taken at a time. Clear and append run one emitting step,
// globalize a read step and then an emitting step; an emitting step waits
// while the output register is occupied, and the next request is accepted
// back in idle. Locate runs a binary search over the end-sum memory between
// an init and a finish step, one registered read and compare per probe.
// The output register lets the next request be accepted while a result
// still waits downstream. Memory contents are undefined after reset; only
// entries below the current count ever affect a result.
`default_nettype none

module segment_offset_map_top
	import som_pkg::*;
#(
	parameter int MAX_SEQS  = 256,
	parameter int POS_WIDTH = 40
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// seq_length[31:0], genome_pos[71:32], seq_id[79:72], seq_offset[111:80]
	input  wire [S_TDATA_W-1:0]  s_tdata,
	// func[1:0]
	input  wire [1:0]            s_tuser,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	// found_index[8:0], found_offset[48:9], global_result[88:49],
	// length_sum[128:89], zero fill[135:129]
	output logic [M_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]           m_tuser
);

	req_t      req_q;
	res_t      res_q;
	res_t      res;
	logic      m_tvalid_q;
	logic      out_free;
	logic      in_ready;
	ctrl_t     ctrl;
	dp_flags_t flags;

	assign s_tready = in_ready;
	assign out_free = !m_tvalid_q || m_tready;

	// request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && in_ready) begin
			req_q.seq_length <= s_tdata[31:0];
			req_q.genome_pos <= s_tdata[71:32];
			req_q.seq_id     <= s_tdata[79:72];
			req_q.seq_offset <= s_tdata[111:80];
		end
	end

	som_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.func     (func_t'(s_tuser)),
		.out_free (out_free),
		.flags    (flags),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	som_datapath #(
		.MAX_SEQS  (MAX_SEQS),
		.POS_WIDTH (POS_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.req    (req_q),
		.flags  (flags),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {{M_PAD_W{1'b0}}, res_q.length_sum, res_q.global_result,
		res_q.found_offset, res_q.found_index};

endmodule

`default_nettype wire

>>> test/segment_offset_map_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_offset_map_top_tb: self-checking bench for the segment offset map
// Streams clear, append, locate and globalize requests with random gaps on
// both sides. A behavioural copy of the length table predicts every result,
// and each returned result is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module segment_offset_map_top_tb;
	import som_pkg::*;

	localparam int MAX_ENTRIES    = 256;
	localparam int RANDOM_TARGET  = 2000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	// one request as queued for the driver
	typedef struct packed {
		func_t func;
		req_t  fields;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = FN_CLEAR;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	request_t request_queue[$];
	res_t due_results[$];
	request_t active_req;

	// table as the block should hold it, updated on each accepted request
	int map_count = 0;
	bit [39:0] map_total = '0;
	bit [39:0] map_end[MAX_ENTRIES];
	bit [31:0] map_len[MAX_ENTRIES];

	// table as it will be once the queued requests are through; steers stimulus
	int plan_count = 0;
	bit [39:0] plan_total = '0;
	bit [39:0] plan_end[MAX_ENTRIES];
	bit [31:0] plan_len[MAX_ENTRIES];

	int src_gap = 0;
	int sink_gap = 0;
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_checked = 0;
	int n_clear = 0, n_append = 0, n_locate = 0, n_glob = 0;
	int n_full = 0, n_range = 0;

	segment_offset_map_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	function automatic logic [39:0] rnd40();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[39:0];
	endfunction

	// mostly short gaps, now and then a long one, none during a steady stretch
	function automatic int pick_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// expected result of one request, advancing the predicted table
	function automatic res_t compute_map_result(input request_t r);
		res_t o;
		int i;
		bit [39:0] base;
		o = '0;
		case (r.func)
			FN_CLEAR: begin
				map_count = 0;
				map_total = '0;
			end
			FN_APPEND: begin
				if (map_count >= MAX_ENTRIES) begin
					o.status = STS_FULL;
				end else begin
					map_total = map_total + r.fields.seq_length;
					map_len[map_count] = r.fields.seq_length;
					map_end[map_count] = map_total;
					map_count++;
				end
			end
			FN_LOCATE: begin
				i = 0;
				while (i < map_count && r.fields.genome_pos >= map_end[i])
					i++;
				o.found_index = i[8:0];
				if (i >= map_count) begin
					o.found_offset = r.fields.genome_pos - map_total;
				end else begin
					base = (i == 0) ? '0 : map_end[i-1];
					o.found_offset = r.fields.genome_pos - base;
				end
				o.status = (r.fields.genome_pos < map_total) ? STS_OK : STS_RANGE;
			end
			default: begin
				if (int'(r.fields.seq_id) < map_count &&
						r.fields.seq_offset < map_len[r.fields.seq_id]) begin
					base = (r.fields.seq_id == 0) ? '0 : map_end[r.fields.seq_id - 1];
					o.global_result = base + r.fields.seq_offset;
				end else begin
					o.status = STS_RANGE;
				end
			end
		endcase
		o.length_sum = map_total;
		return o;
	endfunction

	// queue a request; fields the operation ignores get random values
	task automatic queue_request(input func_t f, input logic [31:0] len,
			input logic [39:0] pos, input logic [7:0] id, input logic [31:0] off);
		request_t r;
		r.func = f;
		r.fields.seq_length = (f == FN_APPEND) ? len : $urandom();
		r.fields.genome_pos = (f == FN_LOCATE) ? pos : rnd40();
		r.fields.seq_id     = (f == FN_GLOBALIZE) ? id : 8'($urandom());
		r.fields.seq_offset = (f == FN_GLOBALIZE) ? off : $urandom();
		request_queue.push_back(r);
		if (f == FN_CLEAR) begin
			plan_count = 0;
			plan_total = '0;
		end else if (f == FN_APPEND && plan_count < MAX_ENTRIES) begin
			plan_total = plan_total + len;
			plan_len[plan_count] = len;
			plan_end[plan_count] = plan_total;
			plan_count++;
		end
	endtask

	function automatic void check_field(input string name, input logic [39:0] want,
			input logic [39:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		res_t predicted;
		logic load_next;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FN_CLEAR;
		end else begin
			load_next = 1'b0;
			if (s_tvalid && s_tready) begin
				predicted = compute_map_result(active_req);
				due_results.push_back(predicted);
				case (active_req.func)
					FN_CLEAR:  n_clear++;
					FN_APPEND: n_append++;
					FN_LOCATE: n_locate++;
					default:   n_glob++;
				endcase
				if (predicted.status == STS_FULL)
					n_full++;
				if (predicted.status == STS_RANGE)
					n_range++;
				if ($urandom_range(0, 63) == 0)
					src_steady = !src_steady;
				src_gap = pick_gap(src_steady);
				load_next = (src_gap == 0 && request_queue.size() > 0);
			end else if (!s_tvalid) begin
				if (src_gap > 0)
					src_gap--;
				else
					load_next = (request_queue.size() > 0);
			end
			if (load_next) begin
				active_req = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {active_req.fields.seq_offset, active_req.fields.seq_id,
					active_req.fields.genome_pos, active_req.fields.seq_length};
				s_tuser <= active_req.func;
			end else if (s_tvalid && s_tready) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and downstream stalls
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (due_results.size() == 0) begin
					$error("result with no request outstanding: status %0d, tdata %0h",
						m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 40'(want.status), 40'(m_tuser));
					check_field("found_index", 40'(want.found_index), 40'(m_tdata[8:0]));
					check_field("found_offset", want.found_offset, m_tdata[48:9]);
					check_field("global_result", want.global_result, m_tdata[88:49]);
					check_field("length_sum", want.length_sum, m_tdata[128:89]);
					check_field("zero fill", '0, 40'(m_tdata[M_TDATA_W-1:129]));
				end
				if ($urandom_range(0, 63) == 0)
					sink_steady = !sink_steady;
				sink_gap = pick_gap(sink_steady);
			end else if (sink_gap == 0 && !sink_steady && $urandom_range(0, 15) == 0) begin
				sink_gap = pick_gap(1'b0);
			end
			if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results still due",
					quiet_cycles, due_results.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int n_app, n_q, k, r, len_mode;
		logic [31:0] len, off;
		logic [39:0] pos;
		logic [7:0] id;
		bit first_fill;

		// empty table: locate and globalize have nothing to find
		queue_request(FN_LOCATE, 0, 40'd0, 0, 0);
		queue_request(FN_LOCATE, 0, '1, 0, 0);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd0, 32'd0);
		// zero length, largest length, then two small ones
		queue_request(FN_APPEND, 32'd0, 0, 0, 0);
		queue_request(FN_APPEND, '1, 0, 0, 0);
		queue_request(FN_APPEND, 32'd1, 0, 0, 0);
		queue_request(FN_APPEND, 32'd5, 0, 0, 0);
		// sequence boundaries, last position, beyond the total
		queue_request(FN_LOCATE, 0, 40'd0, 0, 0);
		queue_request(FN_LOCATE, 0, 40'hFF_FFFF_FFFE, 0, 0);
		queue_request(FN_LOCATE, 0, 40'hFF_FFFF_FFFF, 0, 0);
		queue_request(FN_LOCATE, 0, plan_total - 1, 0, 0);
		queue_request(FN_LOCATE, 0, plan_total, 0, 0);
		queue_request(FN_LOCATE, 0, '1, 0, 0);
		// globalize: empty sequence, last offset, one past, bad indexes
		queue_request(FN_GLOBALIZE, 0, 0, 8'd0, 32'd0);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd1, 32'hFFFF_FFFE);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd1, 32'hFFFF_FFFF);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd3, 32'd4);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd4, 32'd0);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd255, '1);
		// clear, then the table must look empty again
		queue_request(FN_CLEAR, 0, 0, 0, 0);
		queue_request(FN_LOCATE, 0, 40'd5, 0, 0);
		queue_request(FN_GLOBALIZE, 0, 0, 8'd0, 32'd0);

		// random sessions: build a table, then query it; the first fills it up
		first_fill = 1'b1;
		while (request_queue.size() < RANDOM_TARGET + 22) begin
			if (first_fill || $urandom_range(0, 4) != 0)
				queue_request(FN_CLEAR, 0, 0, 0, 0);
			r = $urandom_range(0, 19);
			if (first_fill)
				n_app = MAX_ENTRIES + 3;
			else if (r == 0)
				n_app = $urandom_range(240, 262);
			else if (r < 4)
				n_app = $urandom_range(13, 60);
			else
				n_app = $urandom_range(1, 12);
			len_mode = $urandom_range(0, 3);
			n_q = $urandom_range(10, 60);
			for (int a = 0; a < n_app + n_q; a++) begin
				r = (a < n_app) ? 90 : $urandom_range(0, 99);
				k = (plan_count > 0) ? $urandom_range(0, plan_count - 1) : 0;
				if (r < 45) begin
					case ($urandom_range(0, 7))
						0: pos = plan_end[k];
						1: pos = plan_end[k] - 1;
						2: pos = (k == 0) ? 40'd0 : plan_end[k-1];
						3, 4: pos = (plan_total != 0) ? rnd40() % plan_total : rnd40();
						5: pos = plan_total;
						6: pos = rnd40();
						default: pos = '1;
					endcase
					queue_request(FN_LOCATE, 0, pos, 0, 0);
				end else if (r < 90) begin
					if (plan_count > 0 && $urandom_range(0, 9) < 8)
						id = 8'(k);
					else if (plan_count < MAX_ENTRIES && $urandom_range(0, 1) == 0)
						id = 8'(plan_count);
					else
						id = 8'($urandom_range(0, 255));
					case ($urandom_range(0, 5))
						0, 5: off = (plan_len[id] != 0) ? $urandom() % plan_len[id] : 32'd0;
						1: off = plan_len[id] - 1;
						2: off = plan_len[id];
						3: off = 32'd0;
						default: off = $urandom();
					endcase
					queue_request(FN_GLOBALIZE, 0, 0, id, off);
				end else if (r < 95) begin
					case (len_mode)
						0: len = $urandom_range(0, 20);
						1: len = $urandom_range(0, 5000);
						2: len = $urandom();
						default: begin
							case ($urandom_range(0, 3))
								0: len = 32'd0;
								1: len = '1;
								default: len = $urandom_range(1, 3);
							endcase
						end
					endcase
					queue_request(FN_APPEND, len, 0, 0, 0);
				end else begin
					queue_request(func_t'($urandom_range(0, 3)), $urandom(), rnd40(),
						8'($urandom()), $urandom());
				end
			end
			first_fill = 1'b0;
		end

		// reset, then let the driver and monitor run
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests: %0d clear, %0d append, %0d locate, %0d globalize",
			n_clear, n_append, n_locate, n_glob);
		$display("%0d results checked, %0d full-table appends, %0d out of range, %0d mismatches",
			results_checked, n_full, n_range, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
